/* src/nat_translation_table_assert.svh */
`ifndef NAT_TRANSLATION_TABLE_ASSERT_SVH
`define NAT_TRANSLATION_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NTT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ntt_pkg.sv */
package ntt_pkg;

    localparam int unsigned ENTRY_COUNT_W = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    typedef struct packed {
        logic [31:0] wan_ip;
        logic [15:0] wan_port;
        logic [31:0] lan_ip;
        logic [15:0] lan_port;
    } t_pair;

    typedef struct packed {
        logic cmp_en;
        logic match_all;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

/* src/ntt_cell.sv */
module ntt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntt_pkg::t_cell_ctl i_ctl,
    input  logic [31:0]       i_key_ip,
    input  logic [15:0]       i_key_port,
    input  ntt_pkg::t_pair    i_prev_pair,
    input  logic              i_prev_valid,
    input  ntt_pkg::t_pair    i_next_pair,
    input  logic              i_next_valid,
    input  logic              i_seen,
    input  ntt_pkg::t_pair    i_hit,
    output ntt_pkg::t_pair    o_pair,
    output logic              o_valid,
    output logic              o_seen,
    output ntt_pkg::t_pair    o_hit
);
    import ntt_pkg::*;

    t_pair r_pair;
    logic  r_valid;
    logic  r_match;
    logic  w_wan_hit;
    logic  w_lan_hit;
    logic  w_sel;

    assign w_wan_hit = (r_pair.wan_ip == i_key_ip) && (r_pair.wan_port == i_key_port);
    assign w_lan_hit = (r_pair.lan_ip == i_key_ip) && (r_pair.lan_port == i_key_port);

    // newest match wins: nothing matched in any newer cell
    assign w_sel  = r_match && !i_seen;
    assign o_seen = i_seen || r_match;
    assign o_hit  = t_pair'(i_hit | (w_sel ? r_pair : t_pair'('0)));

    assign o_pair  = r_pair;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid && (i_ctl.match_all || w_wan_hit || w_lan_hit);
            end
            if (i_ctl.ins) begin
                r_valid <= i_prev_valid;
            end else if (i_ctl.del && o_seen) begin
                r_valid <= i_next_valid;
            end
        end
    end

    // shift toward the tail on insert, close the gap on delete
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_pair <= i_prev_pair;
        end else if (i_ctl.del && o_seen) begin
            r_pair <= i_next_pair;
        end
    end

    `include "nat_translation_table_assert.svh"

    `NTT_ASSERT_NEXT(a_cell_hole, i_ctl.ins && !i_prev_valid, !r_valid,
        "cell valid after empty shift")

endmodule

/* src/nat_translation_table.sv */
// NAT mapping table of WAN/LAN address-port pairs held newest first in a row
// of TABLE_DEPTH cells. A request is registered on acceptance, every cell
// compares the key against its WAN and LAN sides in the next cycle, and in
// the update state the newest match is picked through the cell chain, the
// cells shift (insert) or close the gap (delete, remove newest) and the
// response is loaded. The next request is accepted in the cycle after that,
// even while the response still waits to be taken; a response that is not
// taken holds the update state. Insert into a full table is refused with the
// rejected flag; lookup, delete and remove return the entry found (all zero
// when nothing is found) and the entry count.
module nat_translation_table #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_key_ip,
    input  logic [15:0] i_key_port,
    input  logic [31:0] i_wan_ip,
    input  logic [15:0] i_wan_port,
    input  logic [31:0] i_lan_ip,
    input  logic [15:0] i_lan_port,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic        o_found,
    output logic        o_rejected,
    output logic [31:0] o_hit_wan_ip,
    output logic [15:0] o_hit_wan_port,
    output logic [31:0] o_hit_lan_ip,
    output logic [15:0] o_hit_lan_port,
    output logic [ntt_pkg::ENTRY_COUNT_W-1:0] o_entry_count
);
    import ntt_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [1:0]  r_op;
    logic [31:0] r_key_ip;
    logic [15:0] r_key_port;
    t_pair       r_ins_pair;

    logic [CNT_W-1:0] r_count, n_count;

    logic                     r_rsp_valid;
    logic                     r_found;
    logic                     r_rejected;
    t_pair                    r_hit;
    logic [ENTRY_COUNT_W-1:0] r_rsp_count;

    t_cell_ctl w_ctl;
    t_pair     w_pair [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid;
    logic      w_seen [TABLE_DEPTH+1];
    t_pair     w_hit  [TABLE_DEPTH+1];

    logic w_accept;
    logic w_commit;
    logic w_full;
    logic w_is_ins;
    logic w_is_del;
    logic w_found;

    assign o_req_ready = (r_state == S_IDLE);
    assign w_accept    = i_req_valid && o_req_ready;
    assign w_commit    = (r_state == S_UPD) && (!r_rsp_valid || i_rsp_ready);
    assign w_full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_is_ins    = (r_op == OP_INSERT);
    assign w_is_del    = (r_op == OP_DELETE) || (r_op == OP_REMOVE);
    assign w_found     = !w_is_ins && w_seen[TABLE_DEPTH];

    always_comb begin
        w_ctl.cmp_en    = (r_state == S_CMP);
        w_ctl.match_all = (r_op == OP_REMOVE);
        w_ctl.ins       = w_commit && w_is_ins && !w_full;
        w_ctl.del       = w_commit && w_is_del;
    end

    assign w_seen[0] = 1'b0;
    assign w_hit[0]  = t_pair'('0);

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_pair w_prev_pair;
        logic  w_prev_valid;
        t_pair w_next_pair;
        logic  w_next_valid;

        if (g == 0) begin : g_head
            assign w_prev_pair  = r_ins_pair;
            assign w_prev_valid = 1'b1;
        end else begin : g_mid
            assign w_prev_pair  = w_pair[g-1];
            assign w_prev_valid = w_valid[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_next_pair  = t_pair'('0);
            assign w_next_valid = 1'b0;
        end else begin : g_body
            assign w_next_pair  = w_pair[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        ntt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key_ip     (r_key_ip),
            .i_key_port   (r_key_port),
            .i_prev_pair  (w_prev_pair),
            .i_prev_valid (w_prev_valid),
            .i_next_pair  (w_next_pair),
            .i_next_valid (w_next_valid),
            .i_seen       (w_seen[g]),
            .i_hit        (w_hit[g]),
            .o_pair       (w_pair[g]),
            .o_valid      (w_valid[g]),
            .o_seen       (w_seen[g+1]),
            .o_hit        (w_hit[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.del && w_found) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_opcode;
            r_key_ip   <= i_key_ip;
            r_key_port <= i_key_port;
            r_ins_pair <= '{wan_ip: i_wan_ip, wan_port: i_wan_port,
                            lan_ip: i_lan_ip, lan_port: i_lan_port};
        end
        if (w_commit) begin
            r_found     <= w_found;
            r_rejected  <= w_is_ins && w_full;
            r_hit       <= w_found ? w_hit[TABLE_DEPTH] : t_pair'('0);
            r_rsp_count <= ENTRY_COUNT_W'(n_count);
        end
    end

    assign o_rsp_valid    = r_rsp_valid;
    assign o_found        = r_found;
    assign o_rejected     = r_rejected;
    assign o_hit_wan_ip   = r_hit.wan_ip;
    assign o_hit_wan_port = r_hit.wan_port;
    assign o_hit_lan_ip   = r_hit.lan_ip;
    assign o_hit_lan_port = r_hit.lan_port;
    assign o_entry_count  = r_rsp_count;

    `include "nat_translation_table_assert.svh"

    `NTT_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "count above depth")
    `NTT_ASSERT_NOW(a_valid_count, 1'b1, $countones(w_valid) == int'(r_count),
        "valid cells disagree with count")
    `NTT_ASSERT_NOW(a_rsp_flags, o_rsp_valid, !(o_found && o_rejected),
        "found and rejected together")
    `NTT_ASSERT_NEXT(a_del_count, w_ctl.del && w_found, r_count == $past(r_count) - CNT_W'(1),
        "count not reduced after delete")

endmodule

/* sim/nat_translation_table_tb.sv */
`timescale 1ns / 1ps

module nat_translation_table_tb;
    import ntt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int RAND_ITEMS  = 950;
    localparam int STALL_AT    = 120;
    localparam int STALL_LEN   = 400;
    localparam int DRAIN_AT    = 500;
    localparam int POOL_MAX    = 24;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key_ip;
        logic [15:0] key_port;
        t_pair       pair;
    } t_nat_req;

    typedef struct packed {
        logic                     found;
        logic                     rejected;
        t_pair                    hit;
        logic [ENTRY_COUNT_W-1:0] count;
    } t_nat_rsp;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_req_valid = 1'b0;
    logic                     o_req_ready;
    logic [1:0]               i_opcode = OP_INSERT;
    logic [31:0]              i_key_ip = '0;
    logic [15:0]              i_key_port = '0;
    logic [31:0]              i_wan_ip = '0;
    logic [15:0]              i_wan_port = '0;
    logic [31:0]              i_lan_ip = '0;
    logic [15:0]              i_lan_port = '0;
    logic                     o_rsp_valid;
    logic                     i_rsp_ready = 1'b0;
    logic                     o_found;
    logic                     o_rejected;
    logic [31:0]              o_hit_wan_ip;
    logic [15:0]              o_hit_wan_port;
    logic [31:0]              o_hit_lan_ip;
    logic [15:0]              o_hit_lan_port;
    logic [ENTRY_COUNT_W-1:0] o_entry_count;

    t_nat_req req_q[$];
    t_nat_rsp rsp_expect_q[$];
    t_pair    recent_pairs[$];

    t_pair nat_tbl[TABLE_DEPTH];
    int    nat_cnt = 0;

    int   req_cnt = 0;
    int   rsp_cnt = 0;
    int   mismatches = 0;
    int   hold_cycles = 0;
    bit   hold_done = 1'b0;
    logic req_took = 1'b0;
    int   send_idle;
    int   recv_idle;

    nat_translation_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_opcode(i_opcode),
        .i_key_ip(i_key_ip),
        .i_key_port(i_key_port),
        .i_wan_ip(i_wan_ip),
        .i_wan_port(i_wan_port),
        .i_lan_ip(i_lan_ip),
        .i_lan_port(i_lan_port),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_found(o_found),
        .o_rejected(o_rejected),
        .o_hit_wan_ip(o_hit_wan_ip),
        .o_hit_wan_port(o_hit_wan_port),
        .o_hit_lan_ip(o_hit_lan_ip),
        .o_hit_lan_port(o_hit_lan_port),
        .o_entry_count(o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // applies one request to the table copy and returns the response it gives
    function automatic t_nat_rsp nat_table_apply(input logic [1:0] op,
            input logic [31:0] key_ip, input logic [15:0] key_port, input t_pair ins);
        t_nat_rsp r;
        int idx;
        int i;
        r = '0;
        idx = -1;
        case (op) inside
            OP_INSERT: begin
                if (nat_cnt >= TABLE_DEPTH) begin
                    r.rejected = 1'b1;
                end else begin
                    for (i = nat_cnt; i > 0; i--) nat_tbl[i] = nat_tbl[i-1];
                    nat_tbl[0] = ins;
                    nat_cnt++;
                end
            end
            OP_LOOKUP, OP_DELETE: begin
                for (i = 0; i < nat_cnt; i++) begin
                    if (idx < 0 && ((nat_tbl[i].wan_ip == key_ip && nat_tbl[i].wan_port == key_port)
                            || (nat_tbl[i].lan_ip == key_ip && nat_tbl[i].lan_port == key_port)))
                        idx = i;
                end
                if (idx >= 0) begin
                    r.found = 1'b1;
                    r.hit = nat_tbl[idx];
                end
                if (op != OP_DELETE) idx = -1;
            end
            OP_REMOVE: begin
                if (nat_cnt > 0) begin
                    r.found = 1'b1;
                    r.hit = nat_tbl[0];
                    idx = 0;
                end
            end
        endcase
        // close the gap left by a deleted or removed entry
        if (op != OP_INSERT && idx >= 0) begin
            for (i = idx; i + 1 < nat_cnt; i++) nat_tbl[i] = nat_tbl[i+1];
            nat_cnt--;
        end
        r.count = nat_cnt[ENTRY_COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
            input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s at response %0d: expected %h, got %h",
                         name, rsp_cnt, want, got);
        end
    endtask

    function automatic logic [31:0] rand_ip();
        if ($urandom_range(0, 1)) return $urandom;
        return 32'h0A00_0000 | $urandom_range(0, 7);
    endfunction

    function automatic logic [15:0] rand_port();
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 3));
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        p.wan_ip = rand_ip();
        p.wan_port = rand_port();
        p.lan_ip = rand_ip();
        p.lan_port = rand_port();
        return p;
    endfunction

    task automatic add_req(input logic [1:0] op, input logic [31:0] key_ip,
            input logic [15:0] key_port, input t_pair p);
        t_nat_req rq;
        rq.op = op;
        rq.key_ip = key_ip;
        rq.key_port = key_port;
        rq.pair = p;
        req_q.push_back(rq);
        if (op == OP_INSERT) begin
            recent_pairs.push_front(p);
            if (recent_pairs.size() > POOL_MAX) void'(recent_pairs.pop_back());
        end
    endtask

    always_comb begin
        if (req_cnt < 330) begin
            send_idle = 14;
            recv_idle = 60;
        end else if (req_cnt < 660) begin
            send_idle = 60;
            recv_idle = 14;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // request driver
    always @(negedge i_clk) begin : drv
        t_nat_req rq;
        logic go;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (!i_req_valid || req_took) begin
            go = req_q.size() != 0 && $urandom_range(0, 99) >= send_idle
                 && !(req_cnt == DRAIN_AT && rsp_expect_q.size() != 0);
            if (go) begin
                rq = req_q.pop_front();
                i_opcode <= rq.op;
                i_key_ip <= rq.key_ip;
                i_key_port <= rq.key_port;
                i_wan_ip <= rq.pair.wan_ip;
                i_wan_port <= rq.pair.wan_port;
                i_lan_ip <= rq.pair.lan_ip;
                i_lan_port <= rq.pair.lan_port;
            end
            i_req_valid <= go;
        end
    end

    // response ready, with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_cycles != 0) i_rsp_ready <= 1'b0;
        else i_rsp_ready <= $urandom_range(0, 99) >= recv_idle;
    end

    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && rsp_cnt >= STALL_AT) begin
            hold_cycles <= STALL_LEN;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_nat_rsp want;
        t_pair ins;
        req_took = i_rst_n && i_req_valid && o_req_ready;
        if (req_took) begin
            ins = {i_wan_ip, i_wan_port, i_lan_ip, i_lan_port};
            rsp_expect_q.push_back(nat_table_apply(i_opcode, i_key_ip, i_key_port, ins));
            req_cnt++;
        end
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            rsp_cnt++;
            if (rsp_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d arrived with nothing expected", rsp_cnt);
            end else begin
                want = rsp_expect_q.pop_front();
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("rejected", 32'(want.rejected), 32'(o_rejected));
                check_field("hit_wan_ip", want.hit.wan_ip, o_hit_wan_ip);
                check_field("hit_wan_port", 32'(want.hit.wan_port), 32'(o_hit_wan_port));
                check_field("hit_lan_ip", want.hit.lan_ip, o_hit_lan_ip);
                check_field("hit_lan_port", 32'(want.hit.lan_port), 32'(o_hit_lan_port));
                check_field("entry_count", 32'(want.count), 32'(o_entry_count));
            end
        end
    end

    initial begin : stim
        t_pair pc;
        t_pair pd;
        t_pair pk;
        logic [1:0] op;
        logic [31:0] kip;
        logic [15:0] kport;
        int mode;
        int seg_left;
        int roll;
        int k;

        // empty table, extremes, both sides, newest of duplicates
        add_req(OP_REMOVE, '1, '1, '1);
        add_req(OP_LOOKUP, '1, '1, '0);
        add_req(OP_INSERT, '0, '0, '0);
        add_req(OP_INSERT, '1, '1, '1);
        add_req(OP_LOOKUP, '0, '0, '1);
        pc = {32'h0A00_0001, 16'd80, 32'hC0A8_0001, 16'd1234};
        add_req(OP_INSERT, '0, '0, pc);
        add_req(OP_LOOKUP, pc.lan_ip, pc.lan_port, '0);
        add_req(OP_LOOKUP, pc.wan_ip, pc.lan_port, '0);
        pd = {pc.wan_ip, pc.wan_port, 32'hC0A8_0002, 16'd4321};
        add_req(OP_INSERT, '0, '0, pd);
        add_req(OP_LOOKUP, pc.wan_ip, pc.wan_port, '0);
        add_req(OP_DELETE, pc.wan_ip, pc.wan_port, '0);
        // fill up, then one insert too many
        for (k = 0; k < TABLE_DEPTH - 3; k++) add_req(OP_INSERT, '0, '0, rand_pair());
        add_req(OP_INSERT, '1, '1, rand_pair());
        add_req(OP_DELETE, '0, '0, '0);
        add_req(OP_REMOVE, '0, '0, '0);

        // random bursts leaning toward fill, drain or balance
        seg_left = 0;
        mode = 0;
        for (k = 0; k < RAND_ITEMS; k++) begin
            if (seg_left == 0) begin
                mode = $urandom_range(0, 2);
                seg_left = $urandom_range(15, 60);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                0: op = roll < 70 ? OP_INSERT : roll < 85 ? OP_LOOKUP
                      : roll < 95 ? OP_DELETE : OP_REMOVE;
                1: op = roll < 15 ? OP_INSERT : roll < 35 ? OP_LOOKUP
                      : roll < 70 ? OP_DELETE : OP_REMOVE;
                default: op = roll < 35 ? OP_INSERT : roll < 70 ? OP_LOOKUP
                      : roll < 85 ? OP_DELETE : OP_REMOVE;
            endcase
            if (recent_pairs.size() != 0 && $urandom_range(0, 99) < 80) begin
                pk = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                kip = $urandom_range(0, 1) ? pk.wan_ip : pk.lan_ip;
                kport = (kip == pk.wan_ip) ? pk.wan_port : pk.lan_port;
                // near miss on the port
                if ($urandom_range(0, 9) == 0) kport = kport ^ 16'h0001;
            end else begin
                kip = rand_ip();
                kport = rand_port();
            end
            add_req(op, kip, kport, rand_pair());
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_req_valid || rsp_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* nat_translation_table.f */
+incdir+src
src/ntt_pkg.sv
src/ntt_cell.sv
src/nat_translation_table.sv
sim/nat_translation_table_tb.sv
